// File: hw/rtl/tgrp_pkg.sv
// Shared types, constants and codes of the tile grid region planner.
package tgrp_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int COORD_INT_BITS  = 20;
   localparam int MAX_TILES       = 8;
   localparam int IN_W            = COORD_INT_BITS + FRAC_BITS;
   localparam int CW              = IN_W + 2;
   localparam int SW              = IN_W + 3;
   localparam int DVD_W           = IN_W + 1 - FRAC_BITS;
   localparam int TC_W            = DVD_W;
   localparam int TILE_W          = 13;
   localparam int LEVEL_W         = 20;
   localparam int OFF_W           = FRAC_BITS + 2;
   localparam int SRC_W           = 12 + FRAC_BITS;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 20;
   localparam int NUM_DIV_OPS     = 6;

   typedef enum logic [1:0] {
      STATUS_TILE     = 2'd0,
      STATUS_NO_TILE  = 2'd1,
      STATUS_TOO_BIG  = 2'd2
   } tgrp_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_WIDTH   = 3'd0,
      CSR_TILE_HEIGHT  = 3'd1,
      CSR_LEVEL_WIDTH  = 3'd2,
      CSR_LEVEL_HEIGHT = 3'd3,
      CSR_LEVEL_INDEX  = 3'd4,
      CSR_DOWNSAMPLE   = 3'd5
   } tgrp_csr_type;

   typedef enum logic [2:0] {
      OP_START_X = 3'd0,
      OP_END_X   = 3'd1,
      OP_START_Y = 3'd2,
      OP_END_Y   = 3'd3,
      OP_COUNT_X = 3'd4,
      OP_COUNT_Y = 3'd5
   } tgrp_div_op_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_MUL,
      FE_PUSH
   } tgrp_front_state_type;

   typedef struct packed {
      logic [TILE_W-1:0]  tile_width;
      logic [TILE_W-1:0]  tile_height;
      logic [LEVEL_W-1:0] level_width;
      logic [LEVEL_W-1:0] level_height;
      logic [3:0]         level_index;
      logic [3:0]         downsample_log2;
   } tgrp_cfg_type;

   typedef struct packed {
      logic [IN_W-1:0] region_x;
      logic [IN_W-1:0] region_y;
      logic [IN_W-1:0] region_width;
      logic [IN_W-1:0] region_height;
   } tgrp_req_type;

   typedef struct packed {
      logic [COORD_INT_BITS-1:0] tile_col;
      logic [COORD_INT_BITS-1:0] tile_row;
      logic [SRC_W-1:0]          source_x;
      logic [SRC_W-1:0]          source_y;
      logic [IN_W-1:0]           dest_x;
      logic [IN_W-1:0]           dest_y;
      logic [TILE_W-1:0]         visible_width;
      logic [TILE_W-1:0]         visible_height;
      logic [1:0]                op_status;
      logic                      last_op;
   } tgrp_rsp_type;

   typedef struct packed {
      tgrp_status_type status;
      logic [TC_W-1:0] sx;
      logic [TC_W-1:0] ex;
      logic [TC_W-1:0] sy;
      logic [TC_W-1:0] ey;
      logic [CW-1:0]   px0;
      logic [CW-1:0]   py0;
      logic [IN_W-1:0] x;
      logic [IN_W-1:0] y;
      logic [IN_W:0]   xe;
      logic [IN_W:0]   ye;
   } tgrp_cmd_type;

endpackage

// File: hw/rtl/tgrp_div.sv
// Restoring divider, one quotient bit per cycle.
module tgrp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tgrp_pkg::DVD_W-1:0]   dividend,
   input  logic [tgrp_pkg::TILE_W-1:0]  divisor,
   output logic                         done,
   output logic [tgrp_pkg::TC_W-1:0]    quotient
);
   import tgrp_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic [DVD_W-1:0]  dq_ff;
   logic [TILE_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [TILE_W:0]   trial;
   logic              ge;

   assign trial = {rem_ff, dq_ff[DVD_W-1]};
   assign ge    = (trial >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? TILE_W'(trial - {1'b0, divisor}) : trial[TILE_W-1:0];
         dq_ff  <= {dq_ff[DVD_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// File: hw/rtl/tgrp_front.sv
// Front end: accepts a request, finds the clamped tile range and queues a command.
module tgrp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  tgrp_pkg::tgrp_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tgrp_pkg::tgrp_req_type req_data,
   output logic                   cmd_push,
   output tgrp_pkg::tgrp_cmd_type cmd_data,
   input  logic                   cmd_full
);
   import tgrp_pkg::*;

   localparam logic [OFF_W-1:0] HALF3 = OFF_W'(3) << (FRAC_BITS - 1);

   tgrp_front_state_type state_ff, state_in;
   tgrp_div_op_type      op_ff;
   logic                 issued_ff;
   logic [IN_W-1:0]      x_ff, y_ff;
   logic [IN_W:0]        xe_ff, ye_ff;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [TC_W-1:0]      q_ff [NUM_DIV_OPS];
   tgrp_cmd_type         cmd_ff, cmd_in;

   logic                 accept, tiles_zero;
   logic                 div_start, div_done;
   logic [TC_W-1:0]      div_quo;
   logic [DVD_W-1:0]     dividend;
   logic [TILE_W-1:0]    divisor;
   logic [SW-1:0]        bx_s, bx_e, by_s, by_e;
   logic [TC_W-1:0]      exc, eyc, cnt_x, cnt_y;
   logic                 empty_x, empty_y;
   logic [TC_W+TILE_W-1:0] prod_x, prod_y;

   assign accept     = req_valid && req_ready;
   assign tiles_zero = (cfg.tile_width == '0) || (cfg.tile_height == '0);
   assign off_in     = (cfg.level_index == '0) ? '0 : HALF3 - (HALF3 >> cfg.downsample_log2);

   // Shifted start and end (end is inclusive, one LSB in) of the region.
   assign bx_s = SW'(x_ff) - SW'(off_ff);
   assign by_s = SW'(y_ff) - SW'(off_ff);
   assign bx_e = SW'(xe_ff) - SW'(1) - SW'(off_ff);
   assign by_e = SW'(ye_ff) - SW'(1) - SW'(off_ff);

   always_comb begin
      dividend = '0;
      divisor  = cfg.tile_height;
      unique case (op_ff)
         OP_START_X: begin
            dividend = bx_s[SW-1] ? '0 : bx_s[IN_W:FRAC_BITS];
            divisor  = cfg.tile_width;
         end
         OP_END_X: begin
            dividend = bx_e[SW-1] ? '0 : bx_e[IN_W:FRAC_BITS];
            divisor  = cfg.tile_width;
         end
         OP_START_Y: dividend = by_s[SW-1] ? '0 : by_s[IN_W:FRAC_BITS];
         OP_END_Y:   dividend = by_e[SW-1] ? '0 : by_e[IN_W:FRAC_BITS];
         OP_COUNT_X: begin
            dividend = DVD_W'(cfg.level_width) + DVD_W'(cfg.tile_width) - DVD_W'(1);
            divisor  = cfg.tile_width;
         end
         OP_COUNT_Y: dividend = DVD_W'(cfg.level_height) + DVD_W'(cfg.tile_height)
                                - DVD_W'(1);
         default: dividend = '0;
      endcase
   end

   tgrp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Clamp the end tiles to the tile count and classify the range.
   always_comb begin
      exc = (q_ff[OP_END_X] > q_ff[OP_COUNT_X] - 1'b1) ? q_ff[OP_COUNT_X] - 1'b1
                                                        : q_ff[OP_END_X];
      eyc = (q_ff[OP_END_Y] > q_ff[OP_COUNT_Y] - 1'b1) ? q_ff[OP_COUNT_Y] - 1'b1
                                                        : q_ff[OP_END_Y];
      empty_x = bx_e[SW-1] || (q_ff[OP_COUNT_X] == '0) || (exc < q_ff[OP_START_X]);
      empty_y = by_e[SW-1] || (q_ff[OP_COUNT_Y] == '0) || (eyc < q_ff[OP_START_Y]);
      cnt_x   = exc - q_ff[OP_START_X];
      cnt_y   = eyc - q_ff[OP_START_Y];
      prod_x  = q_ff[OP_START_X] * cfg.tile_width;
      prod_y  = q_ff[OP_START_Y] * cfg.tile_height;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE: if (accept) state_in = tiles_zero ? FE_PUSH : FE_DIV;
         FE_DIV:  if (div_done && op_ff == OP_COUNT_Y) state_in = FE_MUL;
         FE_MUL:  state_in = FE_PUSH;
         FE_PUSH: if (!cmd_full) state_in = FE_IDLE;
         default: state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == FE_IDLE);
      div_start = (state_ff == FE_DIV) && !issued_ff;
      cmd_push  = (state_ff == FE_PUSH) && !cmd_full;
   end

   always_comb begin
      cmd_in = cmd_ff;
      if (state_ff == FE_IDLE) begin
         cmd_in        = '0;
         cmd_in.status = STATUS_NO_TILE;
      end else if (state_ff == FE_MUL) begin
         cmd_in.sx  = q_ff[OP_START_X];
         cmd_in.ex  = exc;
         cmd_in.sy  = q_ff[OP_START_Y];
         cmd_in.ey  = eyc;
         cmd_in.px0 = CW'({prod_x[TC_W-1:0], {FRAC_BITS{1'b0}}}) + CW'(off_ff);
         cmd_in.py0 = CW'({prod_y[TC_W-1:0], {FRAC_BITS{1'b0}}}) + CW'(off_ff);
         cmd_in.x   = x_ff;
         cmd_in.y   = y_ff;
         cmd_in.xe  = xe_ff;
         cmd_in.ye  = ye_ff;
         if (empty_x || empty_y) begin
            cmd_in.status = STATUS_NO_TILE;
         end else if (cnt_x >= TC_W'(MAX_TILES) || cnt_y >= TC_W'(MAX_TILES)) begin
            cmd_in.status = STATUS_TOO_BIG;
         end else begin
            cmd_in.status = STATUS_TILE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FE_IDLE;
         op_ff     <= OP_START_X;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            op_ff     <= OP_START_X;
            issued_ff <= 1'b0;
         end else if (div_start) begin
            issued_ff <= 1'b1;
         end else if (div_done) begin
            issued_ff <= 1'b0;
            if (op_ff != OP_COUNT_Y) op_ff <= tgrp_div_op_type'(op_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (accept) begin
         x_ff   <= req_data.region_x;
         y_ff   <= req_data.region_y;
         xe_ff  <= (IN_W+1)'(req_data.region_x) + (IN_W+1)'(req_data.region_width);
         ye_ff  <= (IN_W+1)'(req_data.region_y) + (IN_W+1)'(req_data.region_height);
         off_ff <= off_in;
      end
      if (div_done) q_ff[op_ff] <= div_quo;
   end

   assign cmd_data = cmd_ff;

endmodule

// File: hw/rtl/tgrp_cmd_fifo.sv
// Two-entry command queue between the front end and the tile walker.
module tgrp_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tgrp_pkg::tgrp_cmd_type din,
   output logic                   full,
   input  logic                   pop,
   output tgrp_pkg::tgrp_cmd_type dout,
   output logic                   empty
);
   import tgrp_pkg::*;

   tgrp_cmd_type mem [2];
   logic         wptr_ff, rptr_ff;
   logic [1:0]   cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wptr_ff] <= din;
   end

endmodule

// File: hw/rtl/tgrp_back.sv
// Back end: walks the tile range in row order and drives the result register.
module tgrp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tgrp_pkg::tgrp_cfg_type cfg,
   input  logic                   cmd_empty,
   input  tgrp_pkg::tgrp_cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tgrp_pkg::tgrp_rsp_type rsp_data
);
   import tgrp_pkg::*;

   tgrp_cmd_type    cur_ff;
   logic            active_ff;
   logic [TC_W-1:0] tx_ff, ty_ff;
   logic [CW-1:0]   px_ff, py_ff;
   logic            rsp_valid_ff;
   tgrp_rsp_type    rsp_ff;

   logic            load_ok, emit, row_end, col_end;
   logic [CW-1:0]   tw16, th16, xs, ys, xe, ye;
   logic [CW-1:0]   ix, iy, ir, ib, rr, bb, iw, ih, vw, vh;
   tgrp_rsp_type    tile_rsp, stat_rsp;

   assign load_ok = !rsp_valid_ff || rsp_ready;
   assign cmd_pop = !active_ff && !cmd_empty && load_ok;
   assign emit    = active_ff && load_ok;
   assign col_end = (tx_ff == cur_ff.ex);
   assign row_end = (ty_ff == cur_ff.ey);

   assign tw16 = CW'({cfg.tile_width, {FRAC_BITS{1'b0}}});
   assign th16 = CW'({cfg.tile_height, {FRAC_BITS{1'b0}}});
   assign xs   = CW'(cur_ff.x);
   assign ys   = CW'(cur_ff.y);
   assign xe   = CW'(cur_ff.xe);
   assign ye   = CW'(cur_ff.ye);

   // Overlap of the current tile with the region.
   always_comb begin
      rr = px_ff + tw16;
      bb = py_ff + th16;
      ix = (px_ff > xs) ? px_ff : xs;
      iy = (py_ff > ys) ? py_ff : ys;
      ir = (rr < xe) ? rr : xe;
      ib = (bb < ye) ? bb : ye;
      iw = ir - ix;
      ih = ib - iy;
      vw = iw + CW'((1 << FRAC_BITS) - 1);
      vh = ih + CW'((1 << FRAC_BITS) - 1);
      tile_rsp.tile_col       = tx_ff[COORD_INT_BITS-1:0];
      tile_rsp.tile_row       = ty_ff[COORD_INT_BITS-1:0];
      tile_rsp.source_x       = SRC_W'(ix - px_ff);
      tile_rsp.source_y       = SRC_W'(iy - py_ff);
      tile_rsp.dest_x         = IN_W'(ix - xs);
      tile_rsp.dest_y         = IN_W'(iy - ys);
      tile_rsp.visible_width  = vw[FRAC_BITS +: TILE_W];
      tile_rsp.visible_height = vh[FRAC_BITS +: TILE_W];
      tile_rsp.op_status      = STATUS_TILE;
      tile_rsp.last_op        = col_end && row_end;
      stat_rsp                = '0;
      stat_rsp.op_status      = cmd_data.status;
      stat_rsp.last_op        = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd_pop) begin
            if (cmd_data.status == STATUS_TILE) active_ff <= 1'b1;
            else rsp_valid_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            if (col_end && row_end) active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_data;
         tx_ff  <= cmd_data.sx;
         ty_ff  <= cmd_data.sy;
         px_ff  <= cmd_data.px0;
         py_ff  <= cmd_data.py0;
         if (cmd_data.status != STATUS_TILE) rsp_ff <= stat_rsp;
      end
      if (emit) begin
         rsp_ff <= tile_rsp;
         if (col_end) begin
            tx_ff <= cur_ff.sx;
            px_ff <= cur_ff.px0;
            ty_ff <= ty_ff + 1'b1;
            py_ff <= py_ff + th16;
         end else begin
            tx_ff <= tx_ff + 1'b1;
            px_ff <= px_ff + tw16;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/tile_grid_region_planner.sv
// Top level of the tile grid region planner: configuration registers and block wiring.
//
// A region request (left, top, width, height in unsigned Q20.16 level pixels) is
// transferred on the req_ channel. The block shifts it by the pyramid origin offset,
// finds the covered tile range and returns one rsp_ transfer per tile, in row order,
// with the overlap placement inside the tile and inside the region. The final
// transfer of a request has last_op set. A request that covers no tile, or spans
// more than eight tiles on an axis, gets a single status transfer instead.
// The front end finds the range with one shared divider that produces one
// quotient bit per cycle, running six divisions of 21 bits each per request.
// The back end then emits one tile per cycle while rsp_ready allows, up to 64 per
// request. A two-entry command queue sits between them, so the front end works on
// the next request while tiles of the previous one are still being delivered.
// The result sits in an output register; when rsp_ready is low it holds and the
// walk pauses, while the front end keeps going until the queue is full.
// Registers are written through the csr_ channel, always ready; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Synchronous reset restores the register defaults and empties the queue and the output register.
module tile_grid_region_planner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tgrp_pkg::tgrp_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tgrp_pkg::tgrp_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tgrp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tgrp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tgrp_pkg::*;

   tgrp_cfg_type cfg_ff;
   tgrp_cmd_type push_data, pop_data;
   logic         push, pop, full, empty;

   assign csr_ready = 1'b1;

   // Each register keeps only the low bits of the written value.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width      <= TILE_W'(512);
         cfg_ff.tile_height     <= TILE_W'(512);
         cfg_ff.level_width     <= LEVEL_W'(1);
         cfg_ff.level_height    <= LEVEL_W'(1);
         cfg_ff.level_index     <= 4'd0;
         cfg_ff.downsample_log2 <= 4'd0;
      end else if (csr_valid) begin
         unique case (tgrp_csr_type'(csr_index))
            CSR_TILE_WIDTH:   cfg_ff.tile_width      <= csr_wdata[TILE_W-1:0];
            CSR_TILE_HEIGHT:  cfg_ff.tile_height     <= csr_wdata[TILE_W-1:0];
            CSR_LEVEL_WIDTH:  cfg_ff.level_width     <= csr_wdata[LEVEL_W-1:0];
            CSR_LEVEL_HEIGHT: cfg_ff.level_height    <= csr_wdata[LEVEL_W-1:0];
            CSR_LEVEL_INDEX:  cfg_ff.level_index     <= csr_wdata[3:0];
            CSR_DOWNSAMPLE:   cfg_ff.downsample_log2 <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   tgrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_push  (push),
      .cmd_data  (push_data),
      .cmd_full  (full)
   );

   tgrp_cmd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_data),
      .full  (full),
      .pop   (pop),
      .dout  (pop_data),
      .empty (empty)
   );

   tgrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (empty),
      .cmd_data  (pop_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
